>>> rtl/bslh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslh_pkg: shared types and constants of the lookup2 byte hash
// Holds the job passed from the byte collector to the mixing engine, the
// queue status and the fixed constants of the scheme.
// ----------------------------------------------------------------------------
package bslh_pkg;

    // Start value of words a and b.
    localparam logic [31:0] GOLDEN_RATIO   = 32'h9e37_79b9;
    // Position of the twelfth byte of a block.
    localparam logic [3:0]  BLOCK_LAST_POS = 4'd11;
    // Byte group codes, taken from position bits [3:2].
    localparam logic [1:0]  GRP_A          = 2'd0;
    localparam logic [1:0]  GRP_B          = 2'd1;
    localparam logic [1:0]  GRP_C          = 2'd2;

    // One unit of work for the mixing engine: deltas to add, then one or two mixes.
    typedef struct packed {
        logic        first;     // start of a key: words restart from golden ratio and seed
        logic [31:0] seed;      // seed value sampled at the start of the key
        logic [31:0] da;        // addend for word a
        logic [31:0] db;        // addend for word b
        logic [31:0] dc;        // addend for word c
        logic        two_mix;   // key ends on a block boundary: second mix follows
        logic [31:0] add2;      // addend for word c before the second mix
        logic        emit;      // word c is a result once mixing is done
    } t_job;

    // Status of the job queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/bslh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslh_if: stream channels of the lookup2 byte hash
// Valid/ready channels for key bytes going in and hash words coming out.
// A word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bslh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_key;

    modport source (output valid, output data_byte, output last_byte, output empty_key,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input empty_key,
                    output ready);
endinterface

interface bslh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

>>> rtl/bslh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslh_front: byte collector
// Takes one key byte per cycle while the job queue has room, packs the bytes
// of the current 12-byte block into word addends and hands a job to the queue
// at every block end, key end or empty key.
// ----------------------------------------------------------------------------
module bslh_front import bslh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bslh_in_if.sink     i_byte,
    input  logic [31:0] i_seed,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    logic [3:0]  r_pos,    n_pos;
    logic [31:0] r_len,    n_len;
    logic [31:0] r_da,     n_da;
    logic [31:0] r_db,     n_db;
    logic [23:0] r_chold,  n_chold;
    logic        r_busy,   n_busy;
    logic        r_first,  n_first;
    logic [31:0] r_seed_k, n_seed_k;

    logic        w_acc;
    logic [31:0] w_sh;
    logic [31:0] w_da_new;
    logic [31:0] w_db_new;
    logic [23:0] w_ch_new;
    logic [31:0] w_len_new;
    logic        w_block_done;
    logic        w_first;
    logic [31:0] w_seed_now;

    // A word is taken whenever the queue has room.
    assign i_byte.ready = !i_q_stat.full;
    assign w_acc        = i_byte.valid && i_byte.ready;

    // Place the byte in its lane; lane is the same for all three groups.
    assign w_sh = {24'd0, i_byte.data_byte} << {r_pos[1:0], 3'b000};

    assign w_da_new = r_da | ((r_pos[3:2] == GRP_A) ? w_sh : 32'd0);
    assign w_db_new = r_db | ((r_pos[3:2] == GRP_B) ? w_sh : 32'd0);
    assign w_ch_new = r_chold |
                      (((r_pos[3:2] == GRP_C) && (r_pos != BLOCK_LAST_POS)) ?
                       w_sh[23:0] : 24'd0);

    assign w_len_new    = r_len + 32'd1;
    assign w_block_done = (r_pos == BLOCK_LAST_POS);
    assign w_first      = !r_busy || r_first;
    assign w_seed_now   = r_busy ? r_seed_k : i_seed;

    // Job build and collector state update.
    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_da     = r_da;
        n_db     = r_db;
        n_chold  = r_chold;
        n_busy   = r_busy;
        n_first  = r_first;
        n_seed_k = r_seed_k;
        o_push   = 1'b0;

        o_job.first   = w_first;
        o_job.seed    = w_seed_now;
        o_job.da      = w_da_new;
        o_job.db      = w_db_new;
        o_job.dc      = w_block_done ? {i_byte.data_byte, r_chold}
                                     : ({w_ch_new, 8'd0} + w_len_new);
        o_job.two_mix = w_block_done && i_byte.last_byte;
        o_job.add2    = w_len_new;
        o_job.emit    = i_byte.last_byte;

        if (i_byte.empty_key) begin
            // Empty key: hash of nothing with the current seed.
            o_job.first   = 1'b1;
            o_job.seed    = i_seed;
            o_job.da      = 32'd0;
            o_job.db      = 32'd0;
            o_job.dc      = 32'd0;
            o_job.two_mix = 1'b0;
            o_job.add2    = 32'd0;
            o_job.emit    = 1'b1;
        end

        if (w_acc) begin
            if (i_byte.empty_key || i_byte.last_byte) begin
                // Key finished or dropped: back to idle start values.
                o_push   = 1'b1;
                n_pos    = 4'd0;
                n_len    = 32'd0;
                n_da     = 32'd0;
                n_db     = 32'd0;
                n_chold  = 24'd0;
                n_busy   = 1'b0;
                n_first  = 1'b0;
            end else if (w_block_done) begin
                o_push   = 1'b1;
                n_pos    = 4'd0;
                n_len    = w_len_new;
                n_da     = 32'd0;
                n_db     = 32'd0;
                n_chold  = 24'd0;
                n_busy   = 1'b1;
                n_first  = 1'b0;
                n_seed_k = w_seed_now;
            end else begin
                n_pos    = r_pos + 4'd1;
                n_len    = w_len_new;
                n_da     = w_da_new;
                n_db     = w_db_new;
                n_chold  = w_ch_new;
                n_busy   = 1'b1;
                n_first  = w_first;
                n_seed_k = w_seed_now;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_len   <= 32'd0;
            r_da    <= 32'd0;
            r_db    <= 32'd0;
            r_chold <= 24'd0;
            r_busy  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_da    <= n_da;
            r_db    <= n_db;
            r_chold <= n_chold;
            r_busy  <= n_busy;
            r_first <= n_first;
        end
        r_seed_k <= n_seed_k;
    end

endmodule

>>> rtl/bslh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslh_queue: job queue
// Small first-in first-out buffer that lets the byte collector run ahead of
// the mixing engine.
// ----------------------------------------------------------------------------
module bslh_queue import bslh_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_store [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head       = r_store[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/bslh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslh_back: mixing engine
// Adds each job's addends into words a, b and c, runs the lookup2 mix one
// line per cycle and places the final word c in the output register.
// ----------------------------------------------------------------------------
module bslh_back import bslh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    bslh_out_if.source o_hash
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_MIX,
        S_ADD,
        S_EMIT
    } t_state;

    localparam logic [3:0] MIX_LAST_STEP = 4'd8;

    t_state      r_state, n_state;
    logic [3:0]  r_step,  n_step;
    logic [31:0] r_a,     n_a;
    logic [31:0] r_b,     n_b;
    logic [31:0] r_c,     n_c;
    logic        r_two,   n_two;
    logic        r_emit,  n_emit;
    logic [31:0] r_add2,  n_add2;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_hash,  n_hash;

    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_c;

    assign o_pop             = (r_state == S_LOAD) && !i_q_stat.empty;
    assign o_hash.valid      = r_ovalid;
    assign o_hash.hash_value = r_hash;

    // One line of the mix per step; the nine lines rotate through a, b and c.
    always_comb begin
        w_a = r_a;
        w_b = r_b;
        w_c = r_c;
        unique case (r_step)
            4'd0:    w_a = (r_a - r_b - r_c) ^ (r_c >> 13);
            4'd1:    w_b = (r_b - r_c - r_a) ^ (r_a << 8);
            4'd2:    w_c = (r_c - r_a - r_b) ^ (r_b >> 13);
            4'd3:    w_a = (r_a - r_b - r_c) ^ (r_c >> 12);
            4'd4:    w_b = (r_b - r_c - r_a) ^ (r_a << 16);
            4'd5:    w_c = (r_c - r_a - r_b) ^ (r_b >> 5);
            4'd6:    w_a = (r_a - r_b - r_c) ^ (r_c >> 3);
            4'd7:    w_b = (r_b - r_c - r_a) ^ (r_a << 10);
            4'd8:    w_c = (r_c - r_a - r_b) ^ (r_b >> 15);
            default: w_a = r_a;
        endcase
    end

    // Sequencer: load, mix, optionally add length and mix again, emit if last.
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_two    = r_two;
        n_emit   = r_emit;
        n_add2   = r_add2;
        n_ovalid = r_ovalid;
        n_hash   = r_hash;

        if (r_ovalid && o_hash.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (!i_q_stat.empty) begin
                    n_a     = (i_head.first ? GOLDEN_RATIO : r_a) + i_head.da;
                    n_b     = (i_head.first ? GOLDEN_RATIO : r_b) + i_head.db;
                    n_c     = (i_head.first ? i_head.seed  : r_c) + i_head.dc;
                    n_two   = i_head.two_mix;
                    n_emit  = i_head.emit;
                    n_add2  = i_head.add2;
                    n_step  = 4'd0;
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                n_a    = w_a;
                n_b    = w_b;
                n_c    = w_c;
                n_step = r_step + 4'd1;
                if (r_step == MIX_LAST_STEP) begin
                    n_step = 4'd0;
                    if (r_two) begin
                        n_state = S_ADD;
                    end else if (r_emit) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_ADD: begin
                n_c     = r_c + r_add2;
                n_two   = 1'b0;
                n_state = S_MIX;
            end
            S_EMIT: begin
                if (!r_ovalid || o_hash.ready) begin
                    n_ovalid = 1'b1;
                    n_hash   = r_c;
                    n_state  = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // State and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_step   <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_two  <= n_two;
        r_emit <= n_emit;
        r_add2 <= n_add2;
        r_hash <= n_hash;
    end

endmodule

>>> rtl/byte_stream_lookup2_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_lookup2_hash: lookup2 hash of a byte-streamed key
// Top level: seed register, byte collector, job queue and mixing engine.
// ----------------------------------------------------------------------------
// Key bytes arrive one word per cycle on i_byte and the 32-bit hash of each
// key leaves on o_hash. The collector takes a byte in every cycle that the
// job queue (QUEUE_DEPTH jobs) has room, and hands on a job at each 12-byte
// block end or key end. The mixing engine runs the mix one line per cycle,
// emits the hash after a final job, and for a key ending on a block boundary
// first adds the length and mixes again. Long keys stream at one byte per
// cycle while the queue has room; short keys are bounded by the engine, which
// takes a job only when done with the last, the queue absorbing bursts. The
// seed written on the configuration port is taken at the first byte of a key.
// ----------------------------------------------------------------------------
module byte_stream_lookup2_hash import bslh_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    bslh_in_if.sink     i_byte,
    bslh_out_if.source  o_hash
);

    logic [31:0] r_seed;
    logic        w_push;
    t_job        w_job;
    logic        w_pop;
    t_job        w_head;
    t_q_stat     w_q_stat;

    // Seed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    bslh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_seed   (r_seed),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    bslh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    bslh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_hash   (o_hash)
    );

    // A word that ends or drops a key must hand its job on in the same cycle.
    a_key_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && (i_byte.last_byte || i_byte.empty_key))
        |-> w_push)
        else $error("key end accepted without a job");

    // The collector never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("job queue overflow");

    // The engine never takes a job from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job queue underflow");

endmodule
